/* rtl/etb_pkg.sv */
// shared types, constants and microcode program of the elimination tree builder
package etb_pkg;

   localparam int NODE_W = 8;
   localparam int SIZE_W = 8;
   localparam int ROWS_W = 16;
   localparam int FILL_W = 32;
   localparam int MAX_NODES_DEF = 256;
   localparam logic [ROWS_W-1:0] ROWS_MAX = {ROWS_W{1'b1}};

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_BEGIN = 2'd1,
      OP_ENTRY = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // one word of node storage
   typedef struct packed {
      logic              par_vld;
      logic [NODE_W-1:0] par;
      logic [NODE_W-1:0] mark;
      logic [ROWS_W-1:0] rows;
      logic [SIZE_W-1:0] bsz;
   } node_word_type;

   // microprogram addresses
   typedef logic [3:0] upc_type;
   localparam upc_type UPC_IDLE     = 4'd0;
   localparam upc_type UPC_CLR      = 4'd1;
   localparam upc_type UPC_BEG_RD   = 4'd2;
   localparam upc_type UPC_BEG_WR   = 4'd3;
   localparam upc_type UPC_WALK_RD  = 4'd4;
   localparam upc_type UPC_WALK_UPD = 4'd5;
   localparam upc_type UPC_OK       = 4'd6;
   localparam upc_type UPC_IGN      = 4'd7;
   localparam upc_type UPC_RDN_RD   = 4'd8;
   localparam upc_type UPC_RDN_M1   = 4'd9;
   localparam upc_type UPC_RDN_M2   = 4'd10;
   localparam upc_type UPC_RDN_OUT  = 4'd11;

   typedef enum logic [2:0] {
      JMP_NEXT     = 3'd0,
      JMP_GOTO     = 3'd1,
      JMP_DISPATCH = 3'd2,
      JMP_WALK     = 3'd3,
      JMP_EMIT     = 3'd4
   } jmp_type;

   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_BEGIN = 2'd1,
      WR_WALK  = 2'd2
   } wr_type;

   typedef enum logic [1:0] {
      MUL_NONE = 2'd0,
      MUL_RS   = 2'd1,
      MUL_RR   = 2'd2
   } mul_type;

   typedef enum logic [1:0] {
      EMIT_NONE = 2'd0,
      EMIT_OK   = 2'd1,
      EMIT_IGN  = 2'd2,
      EMIT_READ = 2'd3
   } emit_type;

   // control word
   typedef struct packed {
      logic     fetch;
      logic     rd;
      logic     clr;
      wr_type   wr;
      mul_type  mul;
      emit_type emit;
      jmp_type  jmp;
      upc_type  target;
   } ucode_type;

   // datapath conditions seen by the sequencer
   typedef struct packed {
      logic   req_fire;
      op_type op;
      logic   idx_ok;
      logic   entry_ok;
      logic   walk_done;
      logic   out_free;
   } seq_status_type;

   function automatic ucode_type ucode_rom(input upc_type pc);
      ucode_type uc;
      uc = '{fetch: 1'b0, rd: 1'b0, clr: 1'b0, wr: WR_NONE, mul: MUL_NONE,
             emit: EMIT_NONE, jmp: JMP_GOTO, target: UPC_IDLE};
      case (pc)
         UPC_IDLE: begin
            uc.fetch = 1'b1;
            uc.jmp   = JMP_DISPATCH;
         end
         UPC_CLR: begin
            uc.clr    = 1'b1;
            uc.target = UPC_OK;
         end
         UPC_BEG_RD: begin
            uc.rd  = 1'b1;
            uc.jmp = JMP_NEXT;
         end
         UPC_BEG_WR: begin
            uc.wr     = WR_BEGIN;
            uc.target = UPC_OK;
         end
         UPC_WALK_RD: begin
            uc.rd  = 1'b1;
            uc.jmp = JMP_NEXT;
         end
         UPC_WALK_UPD: begin
            uc.wr     = WR_WALK;
            uc.jmp    = JMP_WALK;
            uc.target = UPC_WALK_RD;
         end
         UPC_OK: begin
            uc.emit = EMIT_OK;
            uc.jmp  = JMP_EMIT;
         end
         UPC_IGN: begin
            uc.emit = EMIT_IGN;
            uc.jmp  = JMP_EMIT;
         end
         UPC_RDN_RD: begin
            uc.rd  = 1'b1;
            uc.jmp = JMP_NEXT;
         end
         UPC_RDN_M1: begin
            uc.mul = MUL_RS;
            uc.jmp = JMP_NEXT;
         end
         UPC_RDN_M2: begin
            uc.mul = MUL_RR;
            uc.jmp = JMP_NEXT;
         end
         UPC_RDN_OUT: begin
            uc.emit = EMIT_READ;
            uc.jmp  = JMP_EMIT;
         end
         default: begin
            uc.jmp = JMP_GOTO;
         end
      endcase
      return uc;
   endfunction

endpackage

/* rtl/etb_ram.sv */
// generic single-write, single-read RAM with registered read data
module etb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/etb_seq.sv */
// microcode sequencer: step counter, control rom and jump logic
module etb_seq import etb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output ucode_type      ctl
);

   upc_type pc_ff, pc_in;

   assign ctl = ucode_rom(pc_ff);

   always_comb begin
      pc_in = pc_ff;
      case (ctl.jmp)
         JMP_NEXT: begin
            pc_in = pc_ff + upc_type'(1);
         end
         JMP_GOTO: begin
            pc_in = ctl.target;
         end
         JMP_DISPATCH: begin
            if (status.req_fire) begin
               if (status.op == OP_CLEAR) begin
                  pc_in = UPC_CLR;
               end else if (!status.idx_ok) begin
                  pc_in = UPC_IGN;
               end else begin
                  case (status.op)
                     OP_BEGIN: pc_in = UPC_BEG_RD;
                     OP_ENTRY: pc_in = status.entry_ok ? UPC_WALK_RD : UPC_IGN;
                     default:  pc_in = UPC_RDN_RD;
                  endcase
               end
            end
         end
         JMP_WALK: begin
            // loop back until a node already marked with the column is met
            pc_in = status.walk_done ? pc_ff + upc_type'(1) : ctl.target;
         end
         JMP_EMIT: begin
            if (status.out_free) begin
               pc_in = ctl.target;
            end
         end
         default: begin
            pc_in = UPC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= UPC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* rtl/elimination_tree_builder.sv */
// elimination tree builder top level: node store, walk datapath and result register
// the entry walk costs one ram read and one ram write per node on the single node store
// a result is registered; the next word is taken while a result still waits downstream
// reset (synchronous) and the clear word empty all per-node valid bits at once;
// no clearing pass runs and the block takes words right after reset
module elimination_tree_builder import etb_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [NODE_W-1:0] req_node_index,
   input  logic [SIZE_W-1:0] req_block_size,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_status,
   output logic              rsp_has_parent,
   output logic [NODE_W-1:0] rsp_parent_node,
   output logic [ROWS_W-1:0] rsp_row_count,
   output logic [FILL_W-1:0] rsp_fill_count
);

   // only indexes a node_index can reach need storage
   localparam int DEPTH = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
   localparam int AW    = $clog2(DEPTH);
   localparam int MUL_W = ROWS_W + 1;

   ucode_type      ctl;
   seq_status_type sts;

   logic req_fire;
   logic idx_ok;
   logic out_free;
   logic emit_fire;
   logic walk_done;

   // current column context
   logic [NODE_W-1:0] col_ff, col_in;
   logic [SIZE_W-1:0] size_ff, size_in;

   // latched word and walk pointer
   logic [NODE_W-1:0] idx_ff, idx_in;
   logic [SIZE_W-1:0] bsz_ff, bsz_in;
   logic [AW-1:0]     node_ff, node_in;

   // one valid bit per node: a node not valid reads as all zero
   logic [DEPTH-1:0] live_ff, live_in;

   node_word_type ram_q, cur, wr_word;
   logic          wr_en;

   logic [ROWS_W:0]   rows_sum;
   logic [ROWS_W-1:0] rows_sat;
   logic [NODE_W-1:0] walk_next;

   // shared multiplier for the fill figure
   logic [MUL_W-1:0]     mul_b;
   logic [2*MUL_W-1:0]   mul_p;
   logic [FILL_W-1:0]    prod_ff, prod_in;
   logic [FILL_W-1:0]    acc_ff, acc_in;
   logic [FILL_W-1:0]    fill_sum;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_has_parent_ff, rsp_has_parent_in;
   logic [NODE_W-1:0] rsp_parent_ff, rsp_parent_in;
   logic [ROWS_W-1:0] rsp_rows_ff, rsp_rows_in;
   logic [FILL_W-1:0] rsp_fill_ff, rsp_fill_in;

   // handshake: a word is only taken in the fetch step
   assign req_stall = !ctl.fetch;
   assign req_fire  = req_valid && ctl.fetch;
   assign idx_ok    = (32'(req_node_index) < 32'(MAX_NODES));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_fire = (ctl.emit != EMIT_NONE) && out_free;

   // conditions for the sequencer
   assign sts.req_fire  = req_fire;
   assign sts.op        = op_type'(req_opcode);
   assign sts.idx_ok    = idx_ok;
   assign sts.entry_ok  = (req_node_index < col_ff);
   assign sts.walk_done = walk_done;
   assign sts.out_free  = out_free;

   etb_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (sts),
      .ctl    (ctl)
   );

   etb_ram #(
      .WIDTH ($bits(node_word_type)),
      .DEPTH (DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (node_ff),
      .wr_data (wr_word),
      .rd_en   (ctl.rd),
      .rd_addr (node_ff),
      .rd_data (ram_q)
   );

   // node word as seen through the valid bit
   assign cur       = live_ff[node_ff] ? ram_q : '0;
   assign walk_done = (cur.mark == col_ff);

   // saturating row count update
   assign rows_sum  = {1'b0, cur.rows} + (ROWS_W + 1)'(size_ff);
   assign rows_sat  = rows_sum[ROWS_W] ? ROWS_MAX : rows_sum[ROWS_W-1:0];
   // an existing parent is followed, a missing one becomes the current column
   assign walk_next = cur.par_vld ? cur.par : col_ff;

   // node store writes
   always_comb begin
      wr_en   = 1'b0;
      wr_word = cur;
      case (ctl.wr)
         WR_BEGIN: begin
            // mark the column with itself and drop its parent, rows stay
            wr_en   = 1'b1;
            wr_word = '{par_vld: 1'b0, par: '0, mark: idx_ff, rows: cur.rows,
                        bsz: bsz_ff};
         end
         WR_WALK: begin
            wr_en   = !walk_done;
            wr_word = '{par_vld: 1'b1, par: walk_next, mark: col_ff, rows: rows_sat,
                        bsz: cur.bsz};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // control and context registers
   always_comb begin
      col_in  = col_ff;
      size_in = size_ff;
      live_in = live_ff;
      idx_in  = idx_ff;
      bsz_in  = bsz_ff;
      node_in = node_ff;
      if (req_fire) begin
         idx_in  = req_node_index;
         bsz_in  = req_block_size;
         node_in = req_node_index[AW-1:0];
      end
      if (ctl.clr) begin
         live_in = '0;
         col_in  = '0;
         size_in = '0;
      end else if (wr_en) begin
         live_in[node_ff] = 1'b1;
      end
      if (ctl.wr == WR_BEGIN) begin
         col_in  = idx_ff;
         size_in = bsz_ff;
      end
      if (ctl.wr == WR_WALK) begin
         node_in = walk_next[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         size_ff <= '0;
         live_ff <= '0;
      end else begin
         col_ff  <= col_in;
         size_ff <= size_in;
         live_ff <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      bsz_ff  <= bsz_in;
      node_ff <= node_in;
   end

   // fill = rows*size + rows*(rows+1)/2, two passes through one multiplier
   assign mul_b = (ctl.mul == MUL_RS) ? MUL_W'(cur.bsz) : MUL_W'(cur.rows) + MUL_W'(1);
   assign mul_p = (2 * MUL_W)'(cur.rows) * (2 * MUL_W)'(mul_b);

   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      case (ctl.mul)
         MUL_RS: begin
            prod_in = mul_p[FILL_W-1:0];
         end
         MUL_RR: begin
            prod_in = mul_p[FILL_W-1:0];
            acc_in  = prod_ff;
         end
         default: begin
            prod_in = prod_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign fill_sum = acc_ff + {1'b0, prod_ff[FILL_W-1:1]};

   // result register
   always_comb begin
      rsp_status_in     = 1'b0;
      rsp_has_parent_in = 1'b0;
      rsp_parent_in     = '0;
      rsp_rows_in       = '0;
      rsp_fill_in       = '0;
      case (ctl.emit)
         EMIT_IGN: begin
            rsp_status_in = 1'b1;
         end
         EMIT_READ: begin
            rsp_has_parent_in = cur.par_vld;
            rsp_parent_in     = cur.par_vld ? cur.par : '0;
            rsp_rows_in       = cur.rows;
            rsp_fill_in       = fill_sum;
         end
         default: begin
            rsp_status_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_has_parent_ff <= rsp_has_parent_in;
         rsp_parent_ff     <= rsp_parent_in;
         rsp_rows_ff       <= rsp_rows_in;
         rsp_fill_ff       <= rsp_fill_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_has_parent  = rsp_has_parent_ff;
   assign rsp_parent_node = rsp_parent_ff;
   assign rsp_row_count   = rsp_rows_ff;
   assign rsp_fill_count  = rsp_fill_ff;

   // clear step empties the store and the column context
   a_clear_effect: assert property (@(posedge clock) disable iff (reset)
      ctl.clr |=> (live_ff == '0 && col_ff == '0 && size_ff == '0))
      else $error("clear step left state behind");

   // the walk never updates the column it is working on
   a_walk_not_column: assert property (@(posedge clock) disable iff (reset)
      (wr_en && ctl.wr == WR_WALK) |-> (NODE_W'(node_ff) != col_ff))
      else $error("walk wrote the current column node");

   // a new result only appears from an emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctl.emit != EMIT_NONE))
      else $error("result raised outside an emit step");

   // every word needs at least one step after the fetch
   a_no_double_fetch: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !ctl.fetch)
      else $error("sequencer fetched twice in a row");

endmodule

/* bench/etb_checker.sv */
// reply checker for the elimination tree builder: predicts every reply and compares it
module etb_checker import etb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [NODE_W-1:0] req_node_index,
   input  logic [SIZE_W-1:0] req_block_size,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_status,
   input  logic              rsp_has_parent,
   input  logic [NODE_W-1:0] rsp_parent_node,
   input  logic [ROWS_W-1:0] rsp_row_count,
   input  logic [FILL_W-1:0] rsp_fill_count,
   output int                fault_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = 1 << NODE_W;

   typedef struct packed {
      logic              status;
      logic              has_parent;
      logic [NODE_W-1:0] parent;
      logic [ROWS_W-1:0] rows;
      logic [FILL_W-1:0] fill;
   } node_reply_type;

   // tree state as the predictor sees it
   bit              link_set  [NODES];
   bit [NODE_W-1:0] link_to   [NODES];
   bit [NODE_W-1:0] col_mark  [NODES];
   bit [ROWS_W-1:0] row_total [NODES];
   bit [SIZE_W-1:0] col_size  [NODES];
   bit [NODE_W-1:0] open_col;
   bit [SIZE_W-1:0] open_size;

   node_reply_type pending_replies[$];
   int             mismatches;
   int             replies_seen;

   task automatic log_fault(input string msg);
      $display("%0t ns: reply %0d: %s", $time, replies_seen, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         log_fault($sformatf("%s is %0h, predicted %0h", name, got, want));
   endtask

   function automatic void forget_tree();
      for (int n = 0; n < NODES; n++) begin
         link_set[n]  = 1'b0;
         link_to[n]   = '0;
         col_mark[n]  = '0;
         row_total[n] = '0;
         col_size[n]  = '0;
      end
      open_col  = '0;
      open_size = '0;
   endfunction

   // climb parent links from a row until a node already marked with the open column
   function automatic void climb_from(input bit [NODE_W-1:0] start);
      bit [NODE_W-1:0] n;
      int unsigned     sum;
      n = start;
      for (int steps = 0; steps < NODES; steps++) begin
         if (col_mark[n] == open_col)
            break;
         if (!link_set[n]) begin
            link_set[n] = 1'b1;
            link_to[n]  = open_col;
         end
         col_mark[n] = open_col;
         sum = row_total[n] + open_size;
         row_total[n] = (sum > ROWS_MAX) ? ROWS_MAX : sum[ROWS_W-1:0];
         n = link_to[n];
      end
   endfunction

   function automatic node_reply_type tree_reply(input op_type op,
                                                 input bit [NODE_W-1:0] idx,
                                                 input bit [SIZE_W-1:0] bsz);
      node_reply_type  r;
      longint unsigned cnt;
      longint unsigned sz;
      r = '0;
      case (op)
         OP_CLEAR: forget_tree();
         OP_BEGIN: begin
            open_col      = idx;
            open_size     = bsz;
            col_size[idx] = bsz;
            col_mark[idx] = idx;
            link_set[idx] = 1'b0;
            link_to[idx]  = '0;
         end
         OP_ENTRY: begin
            if (idx >= open_col)
               r.status = 1'b1;
            else
               climb_from(idx);
         end
         OP_READ: begin
            cnt = row_total[idx];
            sz  = col_size[idx];
            r.has_parent = link_set[idx];
            r.parent     = link_set[idx] ? link_to[idx] : '0;
            r.rows       = row_total[idx];
            r.fill       = FILL_W'(cnt * sz + cnt * (cnt + 1) / 2);
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      node_reply_type want;
      if (reset) begin
         forget_tree();
         pending_replies.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
               log_fault("reply with no word outstanding");
            end else begin
               want = pending_replies.pop_front();
               check_field("status", 64'(rsp_status), 64'(want.status));
               check_field("has_parent", 64'(rsp_has_parent), 64'(want.has_parent));
               check_field("parent_node", 64'(rsp_parent_node), 64'(want.parent));
               check_field("row_count", 64'(rsp_row_count), 64'(want.rows));
               check_field("fill_count", 64'(rsp_fill_count), 64'(want.fill));
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            pending_replies = {pending_replies,
                               tree_reply(op_type'(req_opcode), req_node_index,
                                          req_block_size)};
      end
      // replies still owed count as faults until they arrive
      fault_count = mismatches + pending_replies.size();
   end

endmodule

/* bench/testbench.sv */
// stimulus and verdict for the elimination tree builder, with the reply checker beside it
module testbench import etb_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD    = 12;
   localparam int RESET_CYCLES  = 10;
   localparam int IDLE_PCT      = 38;    // idle cycles per hundred on each side
   localparam int RANDOM_WORDS  = 880;   // random words that the block does not ignore
   localparam int HOLD_CYCLES   = 300;   // one long hold-off on the reply side
   localparam int HAMMER_ROUNDS = 132;   // 264 walks of size 255 overrun the row count
   // longest walk passes every node
   localparam int TAIL_CYCLES   = 600;
   // ~1500 words, each allowed a full-length walk plus stalls and gaps, several times over
   localparam int TIMEOUT_CYCLES = 4_000_000;
   localparam int NODES = 1 << NODE_W;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_opcode;
   logic [NODE_W-1:0] req_node_index;
   logic [SIZE_W-1:0] req_block_size;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_status;
   logic              rsp_has_parent;
   logic [NODE_W-1:0] rsp_parent_node;
   logic [ROWS_W-1:0] rsp_row_count;
   logic [FILL_W-1:0] rsp_fill_count;
   int                fault_count;

   // stimulus bookkeeping: what is open and which nodes may be read
   bit [NODE_W-1:0] open_col;
   bit [NODE_W-1:0] begun_nodes[$];
   int              words_sent;
   int              rsp_taken;
   int              counted;
   bit              steady;    // no idling on either side
   bit              hold_req;  // asks the reply side for its long hold-off

   always #(CLK_PERIOD / 2) clock = ~clock;

   elimination_tree_builder uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_node_index (req_node_index),
      .req_block_size (req_block_size),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_has_parent (rsp_has_parent),
      .rsp_parent_node(rsp_parent_node),
      .rsp_row_count  (rsp_row_count),
      .rsp_fill_count (rsp_fill_count)
   );

   etb_checker tree_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_node_index (req_node_index),
      .req_block_size (req_block_size),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_has_parent (rsp_has_parent),
      .rsp_parent_node(rsp_parent_node),
      .rsp_row_count  (rsp_row_count),
      .rsp_fill_count (rsp_fill_count),
      .fault_count    (fault_count)
   );

   // replies taken, so the sender knows when nothing is owed any more
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         rsp_taken <= rsp_taken + 1;
   end

   // reply side: random stall, one long hold-off counted here, none while steady
   initial begin : reply_side
      bit served;
      served    = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !served) begin
            // replies back up, then the block stops taking words
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            served = 1'b1;
         end
         rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // block sizes: mostly small, often near the top, sometimes anything
   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(3))
         0:       return SIZE_W'($urandom_range(0, 3));
         1:       return SIZE_W'($urandom_range(0, 15));
         2:       return SIZE_W'($urandom_range(250, 255));
         default: return SIZE_W'($urandom_range(255));
      endcase
   endfunction

   // one word: random gaps first, then hold it until the block takes it
   task automatic send_word(input op_type op, input logic [NODE_W-1:0] idx,
                            input logic [SIZE_W-1:0] bsz);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         // junk on the payload while valid is low
         req_valid      <= 1'b0;
         req_opcode     <= 2'($urandom_range(3));
         req_node_index <= NODE_W'($urandom_range(255));
         req_block_size <= SIZE_W'($urandom_range(255));
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_node_index <= idx;
      req_block_size <= bsz;
      do @(posedge clock); while (req_stall !== 1'b0);
      words_sent++;
      // entries on or below the diagonal are ignored and do not count
      if (!(op == OP_ENTRY && idx >= open_col))
         counted++;
      case (op)
         OP_CLEAR: begin
            open_col = '0;
            begun_nodes.delete();
         end
         OP_BEGIN: begin
            open_col = idx;
            begun_nodes = {begun_nodes, idx};
         end
         default: ;
      endcase
      @(negedge clock);
   endtask

   // reads go only to nodes opened since the last clear: others hold no block size
   task automatic read_random_node();
      if (begun_nodes.size() > 0)
         send_word(OP_READ, begun_nodes[$urandom_range(begun_nodes.size() - 1)],
                   SIZE_W'($urandom_range(255)));
   endtask

   // sender goes quiet until every reply has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (rsp_taken != words_sent);
   endtask

   initial begin : stimulus
      int roll;
      int step;
      int col;
      int reps;
      int row;
      int lo;
      int hi;
      bit held;
      bit paused;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_CLEAR;
      req_node_index = '0;
      req_block_size = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: ignored entries, first and last columns, re-opened column, clear
      send_word(OP_ENTRY, 8'd7, 8'hFF);    // nothing open yet, ignored
      send_word(OP_BEGIN, 8'd0, 8'h00);
      send_word(OP_READ, 8'd0, 8'h00);     // empty node, no parent
      send_word(OP_ENTRY, 8'd0, 8'h00);    // on the diagonal, ignored
      send_word(OP_BEGIN, 8'd3, 8'h5A);
      send_word(OP_ENTRY, 8'd0, 8'h00);    // links 0 under 3
      send_word(OP_ENTRY, 8'd0, 8'h00);    // already marked, no change
      send_word(OP_ENTRY, 8'd3, 8'h00);    // on the diagonal
      send_word(OP_BEGIN, 8'd255, 8'hFF);
      send_word(OP_ENTRY, 8'd0, 8'h00);    // walks 0 -> 3 -> 255
      send_word(OP_ENTRY, 8'd254, 8'h00);  // row never opened as a column
      send_word(OP_ENTRY, 8'd255, 8'h00);
      send_word(OP_READ, 8'd0, 8'hFF);
      send_word(OP_READ, 8'd3, 8'hFF);
      send_word(OP_READ, 8'd255, 8'hFF);   // root, no parent
      send_word(OP_BEGIN, 8'd3, 8'h01);    // re-open a lower column, drops its link
      send_word(OP_ENTRY, 8'd0, 8'h00);
      send_word(OP_READ, 8'd3, 8'h00);
      send_word(OP_CLEAR, 8'hFF, 8'hFF);
      send_word(OP_BEGIN, 8'd0, 8'hA5);
      send_word(OP_BEGIN, 8'd1, 8'h00);    // zero block size
      send_word(OP_ENTRY, 8'd0, 8'h00);
      send_word(OP_READ, 8'd0, 8'h00);
      send_word(OP_READ, 8'd1, 8'h00);

      // saturation: two columns opened in turn, every re-open walks the same row again
      send_word(OP_CLEAR, NODE_W'($urandom_range(255)), SIZE_W'($urandom_range(255)));
      lo  = $urandom_range(2, 240);
      hi  = lo + $urandom_range(1, 10);
      row = $urandom_range(0, lo - 1);
      send_word(OP_BEGIN, NODE_W'(row), pick_size());
      for (int r = 0; r < HAMMER_ROUNDS; r++) begin
         send_word(OP_BEGIN, NODE_W'(lo), 8'hFF);
         send_word(OP_ENTRY, NODE_W'(row), SIZE_W'($urandom_range(255)));
         send_word(OP_BEGIN, NODE_W'(hi), 8'hFF);
         send_word(OP_ENTRY, NODE_W'(row), SIZE_W'($urandom_range(255)));
         if (r == HAMMER_ROUNDS / 2)
            send_word(OP_READ, NODE_W'(row), SIZE_W'($urandom_range(255)));
      end
      send_word(OP_READ, NODE_W'(row), SIZE_W'($urandom_range(255)));
      send_word(OP_READ, NODE_W'(lo), SIZE_W'($urandom_range(255)));
      send_word(OP_READ, NODE_W'(hi), SIZE_W'($urandom_range(255)));

      // random: mostly well-formed columns, some noise
      counted = 0;
      held    = 1'b0;
      paused  = 1'b0;
      while (counted < RANDOM_WORDS) begin
         if (!held && counted >= 250) begin
            hold_req = 1'b1;
            held     = 1'b1;
         end
         if (!paused && counted >= 700) begin
            drain_results();
            paused = 1'b1;
         end
         steady = (counted >= 400 && counted < 600);
         roll = $urandom_range(99);
         if (roll < 3) begin
            send_word(OP_CLEAR, NODE_W'($urandom_range(255)), SIZE_W'($urandom_range(255)));
         end else if (roll < 8) begin
            // column opened out of order, stale marks stay behind
            send_word(OP_BEGIN, NODE_W'($urandom_range(255)), pick_size());
         end else if (roll < 12) begin
            send_word(OP_ENTRY, NODE_W'($urandom_range(255)), SIZE_W'($urandom_range(255)));
         end else begin
            // next column up; past the top start again low, sometimes without a clear
            step = $urandom_range(1, 6);
            if (open_col + step > NODES - 1) begin
               if ($urandom_range(1))
                  send_word(OP_CLEAR, NODE_W'($urandom_range(255)),
                            SIZE_W'($urandom_range(255)));
               col = $urandom_range(0, 3);
            end else begin
               col = open_col + step;
            end
            send_word(OP_BEGIN, NODE_W'(col), pick_size());
            reps = $urandom_range(0, 5);
            repeat (reps) begin
               if (col > 0 && $urandom_range(99) < 85)
                  row = $urandom_range(0, col - 1);
               else
                  row = $urandom_range(col, 255);
               send_word(OP_ENTRY, NODE_W'(row), SIZE_W'($urandom_range(255)));
            end
            reps = $urandom_range(0, 2);
            repeat (reps) read_random_node();
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fault_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // hard stop if the block hangs
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/etb_pkg.sv
rtl/etb_ram.sv
rtl/etb_seq.sv
rtl/elimination_tree_builder.sv
bench/etb_checker.sv
bench/testbench.sv
